// ===== hdl/sida_pkg.sv =====
// ----------------------------------------------------------------------------
// sida_pkg: shared types and constants for the signed integer to ASCII block
// Holds the digit chain size, character codes and the per-cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package sida_pkg;

	// width of the incoming two's complement integer
	localparam int ValueWidth = 32;

	// decimal digits needed for the largest 32-bit magnitude
	localparam int DigitCount = 10;

	// width of a counter that can hold DigitCount itself
	localparam int RemWidth = $clog2(DigitCount + 1);

	// width of the bit counter for the conversion sweep
	localparam int BitCntWidth = $clog2(ValueWidth);

	localparam logic [7:0] CharZero  = 8'd48;
	localparam logic [7:0] CharMinus = 8'd45;

	// control word broadcast to every digit cell
	typedef struct packed {
		logic clear;      // zero the digit
		logic shift_bin;  // add-3 correction then shift one binary bit in
		logic shift_dig;  // take the digit of the lower neighbour
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/sida_digit_cell.sv =====
// ----------------------------------------------------------------------------
// sida_digit_cell: one BCD digit of the double-dabble chain
// Holds a single decimal digit. During conversion it corrects and shifts one
// bit in from its lower neighbour; during output it takes that neighbour's
// whole digit, so the chain moves digits towards the top cell.
// ----------------------------------------------------------------------------
`default_nettype none

module sida_digit_cell (
	input  wire logic                  clk,
	input  wire sida_pkg::cell_ctrl_t  ctrl,
	input  wire logic                  bit_in,
	input  wire logic [3:0]            digit_in,
	output logic                       bit_out,
	output logic [3:0]                 digit
);

	logic [3:0] digit_q;
	logic [3:0] adjusted;

	// add 3 when the digit would reach ten after doubling
	always_comb begin
		adjusted = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
	end

	assign bit_out = adjusted[3];
	assign digit   = digit_q;

	// hold, clear, shift a bit or take the neighbour's digit
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= 4'd0;
		end else if (ctrl.shift_bin) begin
			digit_q <= {adjusted[2:0], bit_in};
		end else if (ctrl.shift_dig) begin
			digit_q <= digit_in;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: 32-bit signed integer to decimal ASCII text
// Converts one integer into its decimal characters, most significant first.
// ----------------------------------------------------------------------------
// One integer is taken per value beat and returned as one to eleven char
// beats: '-' for a negative value, then the digits of the magnitude with no
// leading zeros ('0' alone for zero), is_last marking the final character.
// The magnitude of -2147483648 is 2147483648. A row of ten BCD digit cells
// converts the magnitude by double dabble, one binary bit per cycle; leading
// zero digits are then shifted out of the top cell at one per cycle, and the
// characters leave through an output register at one per cycle while the
// char side does not stall. A new value is taken once the last character
// of the previous one is in the output register.
`default_nettype none

module signed_int_to_decimal_ascii (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// integer input channel
	input  wire logic        value_valid,
	output logic             value_stall,
	input  wire logic [31:0] value,
	// character output channel
	output logic             char_valid,
	input  wire logic        char_stall,
	output logic [7:0]       char_code,
	output logic             is_last
);

	localparam logic [1:0] StIdle  = 2'd0;
	localparam logic [1:0] StConv  = 2'd1;
	localparam logic [1:0] StAlign = 2'd2;
	localparam logic [1:0] StEmit  = 2'd3;

	localparam int DigitCount = sida_pkg::DigitCount;
	localparam int RemWidth   = sida_pkg::RemWidth;
	localparam int BitCntW    = sida_pkg::BitCntWidth;

	logic [1:0]                         state_q;
	logic [sida_pkg::ValueWidth-1:0]    mag_q;
	logic [BitCntW-1:0]                 bit_cnt_q;
	logic [RemWidth-1:0]                rem_q;
	logic                               sign_q;
	logic                               out_valid_q;
	logic [7:0]                         char_q;
	logic                               last_q;

	logic                               in_accept;
	logic                               out_free;
	logic                               emit_fire;
	logic                               emit_digit;
	logic [3:0]                         top_digit;
	sida_pkg::cell_ctrl_t               ctrl;
	logic [DigitCount-1:0]              carry_w;
	logic [3:0]                         digit_w [DigitCount];

	assign in_accept   = value_valid && !value_stall;
	assign value_stall = (state_q != StIdle);
	assign out_free    = !out_valid_q || !char_stall;
	assign emit_fire   = (state_q == StEmit) && out_free;
	assign emit_digit  = emit_fire && !sign_q;
	assign top_digit   = digit_w[DigitCount-1];

	// drive the cell chain
	always_comb begin
		ctrl.clear     = in_accept;
		ctrl.shift_bin = (state_q == StConv);
		ctrl.shift_dig = emit_digit
			|| ((state_q == StAlign) && (top_digit == 4'd0) && (rem_q != RemWidth'(1)));
	end

	// build the row of digit cells, lowest digit at index zero
	for (genvar gi = 0; gi < DigitCount; gi++) begin : g_cell
		logic       bit_in;
		logic [3:0] digit_in;
		if (gi == 0) begin : g_first
			assign bit_in   = mag_q[sida_pkg::ValueWidth-1];
			assign digit_in = 4'd0;
		end else begin : g_rest
			assign bit_in   = carry_w[gi-1];
			assign digit_in = digit_w[gi-1];
		end
		sida_digit_cell u_digit (
			.clk      (clk),
			.ctrl     (ctrl),
			.bit_in   (bit_in),
			.digit_in (digit_in),
			.bit_out  (carry_w[gi]),
			.digit    (digit_w[gi])
		);
	end

	// sequence conversion, leading zero removal and character output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			bit_cnt_q   <= '0;
			rem_q       <= '0;
			sign_q      <= 1'b0;
		end else begin
			case (state_q)
				StIdle: begin
					if (in_accept) begin
						state_q   <= StConv;
						bit_cnt_q <= '0;
						rem_q     <= RemWidth'(DigitCount);
						sign_q    <= value[31];
					end
				end
				StConv: begin
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == '1) begin
						state_q <= StAlign;
					end
				end
				StAlign: begin
					if ((top_digit == 4'd0) && (rem_q != RemWidth'(1))) begin
						rem_q <= rem_q - 1'b1;
					end else begin
						state_q <= StEmit;
					end
				end
				StEmit: begin
					if (out_free) begin
						if (sign_q) begin
							sign_q <= 1'b0;
						end else begin
							rem_q <= rem_q - 1'b1;
							if (rem_q == RemWidth'(1)) begin
								state_q <= StIdle;
							end
						end
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	// raise the output beat on a new character, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (!char_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// load the magnitude, then shift it into the chain
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mag_q <= value[31] ? (32'd0 - value) : value;
		end else if (state_q == StConv) begin
			mag_q <= {mag_q[sida_pkg::ValueWidth-2:0], 1'b0};
		end
	end

	// output character register
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			if (sign_q) begin
				char_q <= sida_pkg::CharMinus;
				last_q <= 1'b0;
			end else begin
				char_q <= sida_pkg::CharZero + {4'd0, top_digit};
				last_q <= (rem_q == RemWidth'(1));
			end
		end
	end

	assign char_valid = out_valid_q;
	assign char_code  = char_q;
	assign is_last    = last_q;

	// the top cell never overflows for a 32-bit magnitude
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StConv) |-> !carry_w[DigitCount-1])
		else $error("digit chain overflow");

	// digits remain while aligning or emitting
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == StAlign) || (state_q == StEmit)) |-> (rem_q != '0))
		else $error("digit count exhausted");

	// every emitted character is a digit or the minus sign
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> ((char_code == sida_pkg::CharMinus)
			|| ((char_code >= sida_pkg::CharZero)
			&& (char_code <= sida_pkg::CharZero + 8'd9))))
		else $error("illegal character code");

	// a minus sign is never the last character
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && (char_code == sida_pkg::CharMinus)) |-> !is_last)
		else $error("sign flagged as last");

endmodule

`default_nettype wire
